// File: rtl/posix_cksum_crc32_top_assert.svh
// Assertion macros for the checksum block checker
`ifndef POSIX_CKSUM_CRC32_TOP_ASSERT_SVH
`define POSIX_CKSUM_CRC32_TOP_ASSERT_SVH

// same-cycle implication, off during reset
`define PCRC_AST_IMP(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
        else $error("pcrc assertion failed");

// next-cycle implication, off during reset
`define PCRC_AST_NXT(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
        else $error("pcrc assertion failed");

// next-cycle implication, active during reset
`define PCRC_AST_RST(lbl, clk, a, b) \
    lbl: assert property (@(posedge clk) (a) |=> (b)) \
        else $error("pcrc assertion failed");

`endif

// File: rtl/pcrc_pkg.sv
package pcrc_pkg;

    localparam int LENGTH_BITS_DEF = 48;
    localparam int OUT_COUNT_W     = 48;
    localparam int CRC_W           = 32;
    localparam logic [CRC_W-1:0] CRC_POLY = 32'h04C11DB7;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic CMD_DATA = 1'b0;
    localparam logic CMD_END  = 1'b1;

    typedef struct packed {
        logic       cmd;
        logic [7:0] data_byte;
    } t_req;

    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                  input logic [7:0]       b);
        logic [CRC_W-1:0] c;
        c = crc ^ {b, 24'h000000};
        for (int k = 0; k < 8; k++) begin
            c = c[CRC_W-1] ? ({c[CRC_W-2:0], 1'b0} ^ CRC_POLY) : {c[CRC_W-2:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// File: rtl/pcrc_fifo.sv
module pcrc_fifo import pcrc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_req i_req,
    output logic o_stall,
    output logic o_valid,
    output t_req o_req,
    input  logic i_stall
);

    t_req                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_AW:0]   r_cnt;
    logic [QUEUE_AW:0]   n_cnt;
    logic                push;
    logic                pop;

    assign o_stall = (r_cnt == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_req   = r_mem[r_rd_ptr];
    assign push    = i_valid && !o_stall;
    assign pop     = o_valid && !i_stall;

    always_comb begin
        case ({push, pop})
            2'b10:   n_cnt = r_cnt + (QUEUE_AW+1)'(1);
            2'b01:   n_cnt = r_cnt - (QUEUE_AW+1)'(1);
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (push) begin
                r_wr_ptr <= r_wr_ptr + QUEUE_AW'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + QUEUE_AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_req;
        end
    end

endmodule

// File: rtl/pcrc_engine.sv
module pcrc_engine import pcrc_pkg::*; #(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  t_req                   i_req,
    output logic                   o_stall,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [CRC_W-1:0]       o_checksum,
    output logic [OUT_COUNT_W-1:0] o_byte_count,
    output logic                   o_count_overflow
);

    typedef enum logic {
        ST_RUN,
        ST_LEN
    } t_state;

    t_state                         r_state;
    logic [CRC_W-1:0]               r_crc;
    logic [LENGTH_BITS-1:0]         r_count;
    logic                           r_ovf;
    logic [LENGTH_BITS-1:0]         r_shift;
    logic                           r_out_valid;
    logic [CRC_W-1:0]               r_checksum;
    logic [OUT_COUNT_W-1:0]         r_byte_count;
    logic                           r_count_overflow;
    logic [LENGTH_BITS+OUT_COUNT_W-1:0] count_ext;
    logic                           emit;

    assign count_ext        = {{OUT_COUNT_W{1'b0}}, r_count};
    assign emit             = (r_state == ST_LEN) && (r_shift == '0) &&
                              (!r_out_valid || !i_stall);
    assign o_stall          = (r_state != ST_RUN);
    assign o_valid          = r_out_valid;
    assign o_checksum       = r_checksum;
    assign o_byte_count     = r_byte_count;
    assign o_count_overflow = r_count_overflow;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_RUN;
            r_crc       <= '0;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_shift     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_stall && !emit) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_RUN: begin
                    if (i_valid) begin
                        if (i_req.cmd == CMD_DATA) begin
                            r_crc <= crc_byte(r_crc, i_req.data_byte);
                            if (&r_count) begin
                                r_ovf <= 1'b1;
                            end else begin
                                r_count <= r_count + LENGTH_BITS'(1);
                            end
                        end else begin
                            r_shift <= r_count;
                            r_state <= ST_LEN;
                        end
                    end
                end
                ST_LEN: begin
                    if (r_shift != '0) begin
                        r_crc   <= crc_byte(r_crc, r_shift[7:0]);
                        r_shift <= r_shift >> 8;
                    end else if (emit) begin
                        r_out_valid      <= 1'b1;
                        r_checksum       <= ~r_crc;
                        r_byte_count     <= count_ext[OUT_COUNT_W-1:0];
                        r_count_overflow <= r_ovf;
                        r_crc            <= '0;
                        r_count          <= '0;
                        r_ovf            <= 1'b0;
                        r_state          <= ST_RUN;
                    end
                end
                default: begin
                    r_state <= ST_RUN;
                end
            endcase
        end
    end

endmodule

// File: rtl/posix_cksum_crc32_top.sv
// POSIX cksum CRC-32 engine (polynomial 0x04C11DB7, MSB first, zero start).
// Input channel: i_valid / o_stall with i_cmd and i_data_byte. A request with
// i_cmd = 0 feeds one message byte; i_cmd = 1 ends the message.
// Output channel: o_valid / i_stall with o_checksum, o_byte_count and
// o_count_overflow; one result per end request, none per data byte.
// Requests pass through a two-entry queue into the CRC unit, which folds in
// one byte per cycle, so data bytes are taken at one per cycle sustained while no end request holds the CRC unit.
// An end request holds the CRC unit while the message length is shifted into
// the CRC, least significant byte first, in k bytes (0 to LENGTH_BITS/8,
// rounded up), and then until the result is registered at the output.
// The byte count is LENGTH_BITS wide and saturates, setting o_count_overflow.
// While i_stall holds a result, the queue keeps taking requests and data
// bytes keep flowing; the next result waits in the CRC unit until that one is taken.
// Synchronous reset (i_rst_n low) clears the CRC, the count, the queue and
// the output valid flag; o_stall is low and o_valid low after reset.
module posix_cksum_crc32_top import pcrc_pkg::*; #(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic                   i_cmd,
    input  logic [7:0]             i_data_byte,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [CRC_W-1:0]       o_checksum,
    output logic [OUT_COUNT_W-1:0] o_byte_count,
    output logic                   o_count_overflow
);

    t_req in_req;
    t_req q_req;
    logic q_valid;
    logic q_stall;

    assign in_req.cmd       = i_cmd;
    assign in_req.data_byte = i_data_byte;

    pcrc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_req   (in_req),
        .o_stall (o_stall),
        .o_valid (q_valid),
        .o_req   (q_req),
        .i_stall (q_stall)
    );

    pcrc_engine #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_engine (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (q_valid),
        .i_req            (q_req),
        .o_stall          (q_stall),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_checksum       (o_checksum),
        .o_byte_count     (o_byte_count),
        .o_count_overflow (o_count_overflow)
    );

endmodule

// File: rtl/pcrc_chk.sv
`include "posix_cksum_crc32_top_assert.svh"

module pcrc_chk import pcrc_pkg::*; #(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   o_stall,
    input logic                   o_valid,
    input logic                   i_stall,
    input logic [CRC_W-1:0]       o_checksum,
    input logic [OUT_COUNT_W-1:0] o_byte_count,
    input logic                   o_count_overflow
);

    localparam int CHK_W = (LENGTH_BITS < OUT_COUNT_W) ? LENGTH_BITS : OUT_COUNT_W;

    logic [CRC_W+OUT_COUNT_W:0] out_bus;

    assign out_bus = {o_checksum, o_byte_count, o_count_overflow};

    `PCRC_AST_NXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall,
        o_valid && $stable(out_bus))

    `PCRC_AST_IMP(a_ovf_sat, i_clk, i_rst_n, o_valid && o_count_overflow,
        &o_byte_count[CHK_W-1:0])

    `PCRC_AST_RST(a_rst_idle, i_clk, !i_rst_n, !o_valid && !o_stall)

endmodule

bind posix_cksum_crc32_top pcrc_chk #(.LENGTH_BITS(LENGTH_BITS)) u_chk (.*);

// File: tb/posix_cksum_crc32_top_tb.sv
module posix_cksum_crc32_top_tb;
    import pcrc_pkg::*;

    // narrow count width for the block under test
    localparam int LEN_BITS = 16;
    localparam logic [63:0] COUNT_MAX = {64{1'b1}} >> (64 - LEN_BITS);
    localparam int TAIL_ITEMS = 300;

    typedef struct {
        t_req req;
        bit   drain_first;
    } t_pend;

    typedef struct {
        logic [CRC_W-1:0]       checksum;
        logic [OUT_COUNT_W-1:0] byte_count;
        logic                   count_overflow;
    } t_sum;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_valid = 1'b0;
    logic                   i_cmd = CMD_DATA;
    logic [7:0]             i_data_byte = 8'h00;
    logic                   i_stall = 1'b0;
    logic                   o_stall;
    logic                   o_valid;
    logic [CRC_W-1:0]       o_checksum;
    logic [OUT_COUNT_W-1:0] o_byte_count;
    logic                   o_count_overflow;

    t_pend pend_q[$];
    t_sum  sum_expected_q[$];

    logic [CRC_W-1:0] run_crc = '0;
    logic [63:0]      run_count = '0;
    logic             run_ovf = 1'b0;

    t_req cur_req;
    int   send_gap = 0;
    int   recv_gap = 0;
    int   hold_left = 0;
    bit   hold_done = 1'b0;
    bit   tail_phase = 1'b0;
    int   results_seen = 0;
    int   errors = 0;

    posix_cksum_crc32_top #(
        .LENGTH_BITS(LEN_BITS)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_cmd           (i_cmd),
        .i_data_byte     (i_data_byte),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_checksum      (o_checksum),
        .o_byte_count    (o_byte_count),
        .o_count_overflow(o_count_overflow)
    );

    always #1 i_clk = ~i_clk;

    function automatic logic [CRC_W-1:0] crc_shift_byte(input logic [CRC_W-1:0] crc,
                                                        input logic [7:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {b, 24'h000000};
        for (int k = 0; k < 8; k++) begin
            if (c[CRC_W-1]) begin
                c = (c << 1) ^ 32'h04C11DB7;
            end else begin
                c = c << 1;
            end
        end
        return c;
    endfunction

    task automatic cksum_absorb(input t_req r);
        t_sum        res;
        logic [63:0] rem;
        if (r.cmd == CMD_DATA) begin
            run_crc = crc_shift_byte(run_crc, r.data_byte);
            if (run_count >= COUNT_MAX) begin
                run_count = COUNT_MAX;
                run_ovf   = 1'b1;
            end else begin
                run_count = run_count + 64'd1;
            end
        end else begin
            rem = run_count & COUNT_MAX;
            while (rem != 64'd0) begin
                run_crc = crc_shift_byte(run_crc, rem[7:0]);
                rem     = rem >> 8;
            end
            res.checksum       = ~run_crc;
            res.byte_count     = run_count[OUT_COUNT_W-1:0];
            res.count_overflow = run_ovf;
            sum_expected_q.push_back(res);
            run_crc   = '0;
            run_count = '0;
            run_ovf   = 1'b0;
        end
    endtask

    task automatic queue_request(input logic cmd, input logic [7:0] b, input bit drain);
        t_pend p;
        p.req.cmd       = cmd;
        p.req.data_byte = b;
        p.drain_first   = drain;
        pend_q.push_back(p);
    endtask

    task automatic queue_message(input int len, input bit drain);
        for (int n = 0; n < len; n++) begin
            queue_request(CMD_DATA, 8'($urandom_range(0, 255)), drain && (n == 0));
        end
        queue_request(CMD_END, 8'($urandom_range(0, 255)), drain && (len == 0));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid     <= 1'b0;
            i_cmd       <= CMD_DATA;
            i_data_byte <= 8'h00;
            send_gap    = 0;
        end else if (!i_valid || !o_stall) begin
            if (i_valid) begin
                cksum_absorb(cur_req);
            end
            tail_phase = (pend_q.size() < TAIL_ITEMS);
            if (send_gap > 0) begin
                send_gap--;
                i_valid <= 1'b0;
            end else if (pend_q.size() > 0 &&
                         !(pend_q[0].drain_first && sum_expected_q.size() != 0)) begin
                cur_req = pend_q[0].req;
                void'(pend_q.pop_front());
                i_valid     <= 1'b1;
                i_cmd       <= cur_req.cmd;
                i_data_byte <= cur_req.data_byte;
                if (!tail_phase && $urandom_range(0, 7) == 0) begin
                    send_gap = $urandom_range(1, 3);
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        t_sum exp_sum;
        if (!i_rst_n) begin
            i_stall  <= 1'b0;
            recv_gap = 0;
        end else begin
            if (o_valid && !i_stall) begin
                results_seen++;
                if (sum_expected_q.size() == 0) begin
                    $display("%0t: unexpected result: checksum %h count %h overflow %b",
                             $time, o_checksum, o_byte_count, o_count_overflow);
                    errors++;
                end else begin
                    exp_sum = sum_expected_q.pop_front();
                    if (o_checksum !== exp_sum.checksum) begin
                        $display("%0t: checksum expected %h, got %h",
                                 $time, exp_sum.checksum, o_checksum);
                        errors++;
                    end
                    if (o_byte_count !== exp_sum.byte_count) begin
                        $display("%0t: byte_count expected %h, got %h",
                                 $time, exp_sum.byte_count, o_byte_count);
                        errors++;
                    end
                    if (o_count_overflow !== exp_sum.count_overflow) begin
                        $display("%0t: count_overflow expected %b, got %b",
                                 $time, exp_sum.count_overflow, o_count_overflow);
                        errors++;
                    end
                end
            end
            // hold results long enough for the request queue to back up
            if (!hold_done && results_seen == 20) begin
                hold_done = 1'b1;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (recv_gap > 0) begin
                recv_gap--;
                i_stall <= 1'b1;
            end else if (!tail_phase && $urandom_range(0, 9) == 0) begin
                recv_gap = $urandom_range(0, 2);
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    initial begin
        int random_items;
        int len;
        int pick;

        // two empty messages, the second end request with all data bits high
        queue_request(CMD_END, 8'h00, 1'b0);
        queue_request(CMD_END, 8'hFF, 1'b0);
        queue_request(CMD_DATA, 8'h00, 1'b0);
        queue_request(CMD_DATA, 8'hFF, 1'b0);
        queue_request(CMD_DATA, 8'h80, 1'b0);
        queue_request(CMD_DATA, 8'h01, 1'b0);
        queue_request(CMD_DATA, 8'h7F, 1'b0);
        queue_request(CMD_END, 8'hA5, 1'b0);
        queue_request(CMD_DATA, 8'hA5, 1'b0);
        queue_request(CMD_END, 8'h5A, 1'b0);
        queue_request(CMD_DATA, 8'hFF, 1'b0);
        queue_request(CMD_DATA, 8'hFF, 1'b0);
        queue_request(CMD_DATA, 8'hFF, 1'b0);
        queue_request(CMD_END, 8'h00, 1'b0);
        queue_request(CMD_DATA, 8'h55, 1'b0);
        queue_request(CMD_DATA, 8'hAA, 1'b0);
        queue_request(CMD_END, 8'hFF, 1'b0);

        queue_message(3, 1'b1);
        random_items = 0;
        while (random_items < 2000) begin
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
                len = $urandom_range(250, 700);
            end else if (pick < 3) begin
                len = 0;
            end else begin
                len = $urandom_range(1, 40);
            end
            queue_message(len, $urandom_range(0, 39) == 0);
            random_items += len + 1;
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pend_q.size() != 0 || i_valid || sum_expected_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (30) @(posedge i_clk);
        if (errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
